// File: hdl/stb_pkg.sv
// Shared types and constants for the software timer bank.
package stb_pkg;

	localparam int NUM_SLOTS_DEF = 8;
	localparam int SLOT_W        = 3;
	localparam int TICK_W        = 32;
	localparam int MASK_W        = 8;

	localparam logic [1:0] CMD_START = 2'd0;
	localparam logic [1:0] CMD_SWEEP = 2'd1;
	localparam logic [1:0] CMD_QUERY = 2'd2;

	typedef struct packed {
		logic [1:0]        command;
		logic [SLOT_W-1:0] timer_slot;
		logic [TICK_W-1:0] limit_ms;
		logic [TICK_W-1:0] now_ticks;
	} stb_req_t;

	typedef struct packed {
		logic              done_flag;
		logic              active_flag;
		logic [MASK_W-1:0] expired_mask;
	} stb_rsp_t;

	typedef struct packed {
		logic              vld;
		logic [TICK_W-1:0] now;
		logic [MASK_W-1:0] mask;
	} stb_sweep_t;

endpackage

// File: hdl/software_timer_bank_unit.sv
// Top level of the software timer bank: a chain of timer cells and the response register.
// Start, query and spare: result registered in the cycle after the request is taken.
// Sweep: a token walks the chain one cell per cycle; the final mask is registered as the result.
// Throughput: one start or query per cycle unless a response stalls; sweeps block requests.
// Reset clears every armed and expired mark and the response valid; tick and limit stay unknown.
module software_timer_bank_unit
	import stb_pkg::*;
#(
	parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  stb_req_t req,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	output stb_rsp_t rsp
);

	typedef enum logic {ST_IDLE, ST_SWEEP} state_t;

	state_t             state_q;
	logic               rsp_valid_q;
	stb_rsp_t           rsp_q;
	logic               accept;
	stb_sweep_t         tok [NUM_SLOTS+1];
	logic [NUM_SLOTS-1:0] sel;
	logic [NUM_SLOTS-1:0] armed_v;
	logic [NUM_SLOTS-1:0] expired_v;
	stb_rsp_t           imm_rsp;

	assign req_ready = (state_q == ST_IDLE) && (!rsp_valid_q || rsp_ready);
	assign accept    = req_valid && req_ready;

	assign tok[0].vld  = accept && (req.command == CMD_SWEEP);
	assign tok[0].now  = req.now_ticks;
	assign tok[0].mask = '0;

	genvar gi;
	generate
		for (gi = 0; gi < NUM_SLOTS; gi++) begin : g_cell
			if (gi < (1 << SLOT_W)) begin : g_sel
				assign sel[gi] = (req.timer_slot == SLOT_W'(gi));
			end else begin : g_nosel
				assign sel[gi] = 1'b0;
			end

			stb_cell #(
				.CELL_IDX(gi)
			) u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.start_en   (accept && (req.command == CMD_START) && sel[gi]),
				.start_now  (req.now_ticks),
				.start_limit(req.limit_ms),
				.tok_in     (tok[gi]),
				.tok_out    (tok[gi+1]),
				.armed      (armed_v[gi]),
				.expired    (expired_v[gi])
			);
		end
	endgenerate

	always_comb begin
		imm_rsp = '0;
		unique case (req.command)
			CMD_START: begin
				imm_rsp.active_flag = |sel;
			end
			CMD_QUERY: begin
				imm_rsp.done_flag   = |(expired_v & sel);
				imm_rsp.active_flag = |(armed_v & sel);
			end
			default: begin
				imm_rsp = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			priority if (accept) begin
				if (req.command == CMD_SWEEP) begin
					state_q     <= ST_SWEEP;
					rsp_valid_q <= 1'b0;
				end else begin
					rsp_valid_q <= 1'b1;
					rsp_q       <= imm_rsp;
				end
			end else if (tok[NUM_SLOTS].vld) begin
				state_q            <= ST_IDLE;
				rsp_valid_q        <= 1'b1;
				rsp_q.done_flag    <= 1'b0;
				rsp_q.active_flag  <= 1'b0;
				rsp_q.expired_mask <= tok[NUM_SLOTS].mask;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// File: hdl/stb_cell.sv
// One timer slot: holds its start tick, limit and marks, and passes the sweep token on.
module stb_cell
	import stb_pkg::*;
#(
	parameter int CELL_IDX = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start_en,
	input  logic [TICK_W-1:0] start_now,
	input  logic [TICK_W-1:0] start_limit,
	input  stb_sweep_t        tok_in,
	output stb_sweep_t        tok_out,
	output logic              armed,
	output logic              expired
);

	logic [TICK_W-1:0] start_q;
	logic [TICK_W-1:0] limit_q;
	logic              armed_q;
	logic              expired_q;
	stb_sweep_t        tok_q;
	logic [TICK_W-1:0] elapsed;
	logic              hit;
	logic [MASK_W-1:0] own_bit;

	generate
		if (CELL_IDX < MASK_W) begin : g_bit
			assign own_bit = MASK_W'(1) << CELL_IDX;
		end else begin : g_nobit
			assign own_bit = '0;
		end
	endgenerate

	assign elapsed = tok_in.now - start_q;
	assign hit     = tok_in.vld && armed_q && (elapsed >= limit_q);

	always_ff @(posedge clk) begin
		if (start_en) begin
			start_q <= start_now;
			limit_q <= start_limit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q   <= 1'b0;
			expired_q <= 1'b0;
			tok_q     <= '0;
		end else begin
			if (start_en) begin
				armed_q   <= 1'b1;
				expired_q <= 1'b0;
			end else if (hit) begin
				armed_q   <= 1'b0;
				expired_q <= 1'b1;
			end
			tok_q.vld  <= tok_in.vld;
			tok_q.now  <= tok_in.now;
			tok_q.mask <= hit ? (tok_in.mask | own_bit) : tok_in.mask;
		end
	end

	assign tok_out = tok_q;
	assign armed   = armed_q;
	assign expired = expired_q;

endmodule

// File: hdl/stb_checker.sv
// Port-level checks for the software timer bank, bound to the top level.
module stb_checker
	import stb_pkg::*;
#(
	parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
	input logic     clk,
	input logic     arst_n,
	input logic     req_valid,
	input logic     req_ready,
	input stb_req_t req,
	input logic     rsp_valid,
	input logic     rsp_ready,
	input stb_rsp_t rsp
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response beat changed while stalled");

	a_start_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (req.command == CMD_START)
		|=> rsp_valid && !rsp.done_flag && (rsp.expired_mask == '0))
		else $error("bad start response");

	a_query_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (req.command == CMD_QUERY)
		|=> rsp_valid && (rsp.expired_mask == '0))
		else $error("bad query response");

	a_marks_excl: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp.done_flag && rsp.active_flag))
		else $error("slot reported both expired and armed");

	a_sweep_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (req.command == CMD_SWEEP)
		|=> !req_ready && !rsp_valid)
		else $error("request taken or response shown during sweep");

endmodule

bind software_timer_bank_unit stb_checker #(.NUM_SLOTS(NUM_SLOTS)) u_stb_checker (.*);

// File: verif/software_timer_bank_unit_tb.sv
// Self-checking testbench for the software timer bank: directed table, random traffic, scoreboard.
module software_timer_bank_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import stb_pkg::*;

	localparam int         BANK_SLOTS       = NUM_SLOTS_DEF;
	localparam logic [1:0] CMD_SPARE        = 2'd3;
	localparam int         RANDOM_PER_PHASE = 500;
	localparam int         HOLD_OFF_CYCLES  = 300;
	localparam int         SETTLE_CYCLES    = 4 * BANK_SLOTS + 20;
	localparam int         CYCLE_LIMIT      = 400000;
	localparam bit         TYPED            = 1'b1;
	localparam bit         PREDICTED        = 1'b0;

	localparam stb_rsp_t RSP_IDLE  = '0;
	localparam stb_rsp_t RSP_ARMED = '{done_flag: 1'b0, active_flag: 1'b1, expired_mask: '0};

	typedef struct {
		stb_req_t item;
		bit       typed;
		stb_rsp_t want;
	} stim_row_t;

	logic     clk;
	logic     arst_n    = 1'b0;
	logic     req_valid = 1'b0;
	logic     req_ready;
	stb_req_t req       = '0;
	logic     rsp_valid;
	logic     rsp_ready = 1'b0;
	stb_rsp_t rsp;

	logic [TICK_W-1:0] slot_start   [BANK_SLOTS];
	logic [TICK_W-1:0] slot_limit   [BANK_SLOTS];
	logic              slot_armed   [BANK_SLOTS];
	logic              slot_expired [BANK_SLOTS];

	stb_rsp_t    pending_rsp [$];
	stim_row_t   stim_table  [$];
	logic [TICK_W-1:0] tick_now;
	int          send_idle_pct;
	int          rcv_idle_pct;
	int          phase_idx;
	bit          pressure_done;
	int          errors;
	int          beats_sent;
	int          results_checked;
	int          expiring_sweeps;
	logic [MASK_W-1:0] mask_bits_seen;
	int          cycles;

	software_timer_bank_unit #(
		.NUM_SLOTS(BANK_SLOTS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending", cycles, pending_rsp.size());
			$display("simulation failed");
			$finish;
		end
	end

	function automatic stb_rsp_t timer_bank_next(input stb_req_t item);
		stb_rsp_t          res;
		logic [TICK_W-1:0] elapsed;
		res = '0;
		case (item.command)
		CMD_START: begin
			if (item.timer_slot < BANK_SLOTS) begin
				slot_start[item.timer_slot]   = item.now_ticks;
				slot_limit[item.timer_slot]   = item.limit_ms;
				slot_armed[item.timer_slot]   = 1'b1;
				slot_expired[item.timer_slot] = 1'b0;
				res.active_flag = 1'b1;
			end
		end
		CMD_SWEEP: begin
			for (int i = 0; i < BANK_SLOTS; i++) begin
				if (slot_armed[i]) begin
					elapsed = item.now_ticks - slot_start[i];
					if (elapsed >= slot_limit[i]) begin
						slot_expired[i] = 1'b1;
						slot_armed[i]   = 1'b0;
						if (i < MASK_W)
							res.expired_mask[i] = 1'b1;
					end
				end
			end
		end
		CMD_QUERY: begin
			if (item.timer_slot < BANK_SLOTS) begin
				res.done_flag   = slot_expired[item.timer_slot];
				res.active_flag = slot_armed[item.timer_slot];
			end
		end
		default: res = '0;
		endcase
		return res;
	endfunction

	function automatic stb_req_t next_random_item();
		stb_req_t item;
		int       pick;
		pick = $urandom_range(99);
		if (pick < 35)
			item.command = CMD_START;
		else if (pick < 65)
			item.command = CMD_SWEEP;
		else if (pick < 95)
			item.command = CMD_QUERY;
		else
			item.command = CMD_SPARE;
		item.timer_slot = SLOT_W'($urandom_range(BANK_SLOTS - 1));
		pick = $urandom_range(99);
		if (pick < 70)
			item.limit_ms = $urandom_range(200);
		else if (pick < 85)
			item.limit_ms = $urandom;
		else if (pick < 92)
			item.limit_ms = '0;
		else
			item.limit_ms = '1;
		if ($urandom_range(99) < 8)
			tick_now = $urandom;
		else
			tick_now = tick_now + $urandom_range(40);
		item.now_ticks = tick_now;
		return item;
	endfunction

	task automatic add_row(input logic [1:0] cmd, input int slot, input logic [TICK_W-1:0] lim,
			input logic [TICK_W-1:0] now, input bit typed, input stb_rsp_t want);
		stim_row_t row;
		row.item.command    = cmd;
		row.item.timer_slot = SLOT_W'(slot);
		row.item.limit_ms   = lim;
		row.item.now_ticks  = now;
		row.typed           = typed;
		row.want            = want;
		stim_table.push_back(row);
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("[%0t] mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
		errors++;
	endtask

	task automatic drive_beat(input stb_req_t item, input bit typed, input stb_rsp_t want);
		int       gap;
		stb_rsp_t predicted;
		gap = 0;
		while (gap < 40 && $urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= item;
		do @(posedge clk); while (!req_ready);
		predicted = timer_bank_next(item);
		pending_rsp.push_back(typed ? want : predicted);
		beats_sent++;
	endtask

	task automatic check_result(input stb_rsp_t got);
		stb_rsp_t want;
		results_checked++;
		if (pending_rsp.size() == 0) begin
			report_mismatch("result with nothing pending", 32'(got), 32'(0));
		end else begin
			want = pending_rsp.pop_front();
			if (got.done_flag !== want.done_flag)
				report_mismatch("done_flag", 32'(got.done_flag), 32'(want.done_flag));
			if (got.active_flag !== want.active_flag)
				report_mismatch("active_flag", 32'(got.active_flag), 32'(want.active_flag));
			if (got.expired_mask !== want.expired_mask)
				report_mismatch("expired_mask", 32'(got.expired_mask),
					32'(want.expired_mask));
		end
		if (got.expired_mask != '0)
			expiring_sweeps++;
		mask_bits_seen = mask_bits_seen | got.expired_mask;
	endtask

	initial begin
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (rsp_valid && rsp_ready)
				check_result(rsp);
			if (phase_idx == 2 && !pressure_done) begin
				hold_left     = HOLD_OFF_CYCLES;
				pressure_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= ($urandom_range(99) >= rcv_idle_pct);
			end
		end
	end

	initial begin
		for (int i = 0; i < BANK_SLOTS; i++) begin
			slot_start[i]   = '0;
			slot_limit[i]   = '0;
			slot_armed[i]   = 1'b0;
			slot_expired[i] = 1'b0;
		end
		tick_now        = $urandom;
		send_idle_pct   = 30;
		rcv_idle_pct    = 77;
		phase_idx       = 0;
		mask_bits_seen  = '0;

		add_row(CMD_QUERY, 0, 0, 0, TYPED, RSP_IDLE);
		add_row(CMD_QUERY, 7, 0, 0, TYPED, RSP_IDLE);
		add_row(CMD_SWEEP, 0, 0, 0, TYPED, RSP_IDLE);
		add_row(CMD_SPARE, 5, '1, '1, TYPED, RSP_IDLE);
		add_row(CMD_START, 0, 0, 0, TYPED, RSP_ARMED);
		add_row(CMD_START, 7, '1, '1, TYPED, RSP_ARMED);
		add_row(CMD_START, 3, 100, 32'hFFFF_FFF0, TYPED, RSP_ARMED);
		add_row(CMD_QUERY, 0, 0, 0, PREDICTED, RSP_IDLE);
		add_row(CMD_SWEEP, 0, 0, 0, PREDICTED, RSP_IDLE);
		add_row(CMD_QUERY, 0, 0, 0, PREDICTED, RSP_IDLE);
		add_row(CMD_SWEEP, 0, 0, 32'h53, PREDICTED, RSP_IDLE);
		add_row(CMD_SWEEP, 0, 0, 32'h54, PREDICTED, RSP_IDLE);
		add_row(CMD_START, 5, 10, 1000, PREDICTED, RSP_IDLE);
		add_row(CMD_START, 5, 1000, 1000, PREDICTED, RSP_IDLE);
		add_row(CMD_SWEEP, 0, 0, 1010, PREDICTED, RSP_IDLE);
		add_row(CMD_QUERY, 5, 0, 0, PREDICTED, RSP_IDLE);
		add_row(CMD_START, 1, 0, 32'hAAAA_AAAA, PREDICTED, RSP_IDLE);
		add_row(CMD_START, 2, 0, 32'hAAAA_AAAA, PREDICTED, RSP_IDLE);
		add_row(CMD_START, 4, 0, 32'hAAAA_AAAA, PREDICTED, RSP_IDLE);
		add_row(CMD_START, 6, 32'h7FFF_FFFF, 32'hAAAA_AAAA, PREDICTED, RSP_IDLE);
		add_row(CMD_SWEEP, 0, 0, 32'hFFFF_FFFE, PREDICTED, RSP_IDLE);
		add_row(CMD_START, 0, 0, 0, PREDICTED, RSP_IDLE);
		add_row(CMD_START, 3, 0, 0, PREDICTED, RSP_IDLE);
		add_row(CMD_SWEEP, 0, 0, 32'h8000_0000, PREDICTED, RSP_IDLE);
		add_row(CMD_QUERY, 7, 0, 0, PREDICTED, RSP_IDLE);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_table[r])
			drive_beat(stim_table[r].item, stim_table[r].typed, stim_table[r].want);

		for (int p = 0; p < 3; p++) begin
			phase_idx     = p;
			send_idle_pct = (p == 0) ? 30 : (p == 1) ? 77 : 0;
			rcv_idle_pct  = (p == 0) ? 77 : (p == 1) ? 30 : 0;
			repeat (RANDOM_PER_PHASE)
				drive_beat(next_random_item(), PREDICTED, RSP_IDLE);
		end
		req_valid <= 1'b0;

		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("covered %0d beats in three idle mixes plus a %0d-cycle result hold-off",
			beats_sent, HOLD_OFF_CYCLES);
		$display("checked %0d results; %0d sweeps expired slots, mask bits seen %b",
			results_checked, expiring_sweeps, mask_bits_seen);
		if (errors == 0 && pending_rsp.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
